@@ hdl/msre_pkg.sv @@
// msre_pkg: shared types, codes and sizes of the modbus slave request engine
// used by msre_packer and modbus_slave_request_engine; depends on nothing
package msre_pkg;

   localparam int REGISTER_DEPTH  = 64;
   localparam int BIT_POINT_DEPTH = 512;
   localparam int FRAME_CAPACITY  = 256;
   localparam int MIN_FRAME_BYTES = 4;
   localparam int HDR_BYTES       = 6;

   localparam int HR_AW  = $clog2(REGISTER_DEPTH);
   localparam int BP_AW  = $clog2(BIT_POINT_DEPTH);
   localparam int BUF_AW = $clog2(FRAME_CAPACITY);
   localparam int LEN_W  = $clog2(FRAME_CAPACITY + 1);
   localparam int HDR_AW = $clog2(HDR_BYTES);

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 5;

   // input opcodes
   localparam logic [1:0] OP_FRAME     = 2'd0;
   localparam logic [1:0] OP_REG_WRITE = 2'd1;
   localparam logic [1:0] OP_INPUT_SET = 2'd2;
   localparam logic [1:0] OP_READ      = 2'd3;

   // result status
   localparam logic [2:0] ST_RESPONSE = 3'd0;
   localparam logic [2:0] ST_DROPPED  = 3'd1;
   localparam logic [2:0] ST_DONE     = 3'd2;
   localparam logic [2:0] ST_REJECTED = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;

   // change notice kinds
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_COILS   = 2'd1;
   localparam logic [1:0] KIND_HOLDING = 2'd2;

   // function codes
   localparam logic [7:0] FC_READ_INPUTS  = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING = 8'd3;
   localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
   localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS   = 8'd16;
   localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
   localparam logic [15:0] COIL_ON        = 16'hFF00;

   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;

   // register indexes
   localparam logic [1:0] REG_UNIT_ID  = 2'd0;
   localparam logic [1:0] REG_DI_COUNT = 2'd1;
   localparam logic [1:0] REG_HR_COUNT = 2'd2;
   localparam logic [1:0] REG_CL_COUNT = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LREAD, S_DECODE, S_DROP, S_EXC, S_RHDR,
      S_DI_RD, S_DI_ACC, S_DI_PUSH, S_HR_RD, S_HR_HI, S_HR_LO,
      S_SCOIL, S_WC_RD, S_WC_BYTE, S_WC_WR, S_WR_RDH, S_WR_RDL, S_WR_WR, S_ECHO
   } state_type;

   // one byte (or an empty result) handed to the packer
   typedef struct packed {
      logic        valid;
      logic        has_byte;
      logic [7:0]  data;
      logic        last;
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [8:0]  start;
      logic [9:0]  count;
      logic        coil;
      logic [15:0] reg_value;
   } push_type;

endpackage

@@ hdl/msre_packer.sv @@
// msre_packer: packs response bytes eight to a word behind an output register
// depends on msre_pkg
module msre_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  msre_pkg::push_type            push,
   output logic                          push_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // response_word, response_bytes, change_start, change_count, read_coil, read_register
   output logic [msre_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   // status, change_kind
   output logic [msre_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        out_valid_ff, out_valid_in;
   logic [msre_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;
   logic [msre_pkg::RSP_USER_W-1:0] out_user_ff, out_user_in;
   logic [63:0] word;
   logic [3:0]  nb;

   assign push_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      word         = acc_ff;
      nb           = cnt_ff;
      // first byte lands in the top lane
      for (int k = 0; k < 8; k++) begin
         if (push.has_byte && cnt_ff == 4'(k)) begin
            word[63-8*k -: 8] = push.data;
         end
      end
      if (push.has_byte) begin
         nb = cnt_ff + 4'd1;
      end
      if (push.valid) begin
         if (push.last || nb == 4'd8) begin
            out_valid_in = 1'b1;
            out_data_in  = {push.reg_value, push.coil, push.count, push.start, nb, word};
            out_last_in  = push.last;
            out_user_in  = {push.kind, push.status};
            acc_in       = '0;
            cnt_in       = '0;
         end else begin
            acc_in = word;
            cnt_in = nb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

@@ hdl/modbus_slave_request_engine.sv @@
// modbus slave request engine: a register write or input set result goes to the packer as
// it is taken, a read first passes a read state; end of frame: a decode state, then header,
// echo and input data bytes are pushed; each input bit is read, accumulated; each register
// read is pushed high, low byte; coils are written after each data byte read; registers are
// read high, read low, written; a full output register stalls every byte; reset: a clearing
// pass zeroes the stores, no word is taken meanwhile; depends on msre_pkg and msre_packer
module modbus_slave_request_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // frame_byte, local_address, local_value, zero pad
   input  logic [msre_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic        req_tlast,
   // opcode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // response_word, response_bytes, change_start, change_count, read_coil, read_register
   output logic [msre_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast,
   // status, change_kind
   output logic [msre_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int HR_AW  = msre_pkg::HR_AW;
   localparam int BP_AW  = msre_pkg::BP_AW;
   localparam int BUF_AW = msre_pkg::BUF_AW;
   localparam int LEN_W  = msre_pkg::LEN_W;
   localparam int HDR_N  = msre_pkg::HDR_BYTES;

   // configuration
   logic [7:0] unit_ff;
   logic [9:0] di_cnt_ff;
   logic [6:0] hr_cnt_ff;
   logic [9:0] cl_cnt_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= 8'd1;
         di_cnt_ff <= 10'(msre_pkg::BIT_POINT_DEPTH);
         hr_cnt_ff <= 7'(msre_pkg::REGISTER_DEPTH);
         cl_cnt_ff <= 10'(msre_pkg::BIT_POINT_DEPTH);
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            msre_pkg::REG_UNIT_ID:  unit_ff   <= csr_pwdata[7:0];
            msre_pkg::REG_DI_COUNT: di_cnt_ff <= csr_pwdata[9:0];
            msre_pkg::REG_HR_COUNT: hr_cnt_ff <= csr_pwdata[6:0];
            msre_pkg::REG_CL_COUNT: cl_cnt_ff <= csr_pwdata[9:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         msre_pkg::REG_UNIT_ID:  csr_prdata = {24'd0, unit_ff};
         msre_pkg::REG_DI_COUNT: csr_prdata = {22'd0, di_cnt_ff};
         msre_pkg::REG_HR_COUNT: csr_prdata = {25'd0, hr_cnt_ff};
         msre_pkg::REG_CL_COUNT: csr_prdata = {22'd0, cl_cnt_ff};
      endcase
   end

   logic [9:0] eff_di, eff_cl;
   logic [6:0] eff_hr;
   assign eff_di = (di_cnt_ff > 10'(msre_pkg::BIT_POINT_DEPTH)) ?
                   10'(msre_pkg::BIT_POINT_DEPTH) : di_cnt_ff;
   assign eff_cl = (cl_cnt_ff > 10'(msre_pkg::BIT_POINT_DEPTH)) ?
                   10'(msre_pkg::BIT_POINT_DEPTH) : cl_cnt_ff;
   assign eff_hr = (hr_cnt_ff > 7'(msre_pkg::REGISTER_DEPTH)) ?
                   7'(msre_pkg::REGISTER_DEPTH) : hr_cnt_ff;

   // input word fields
   logic [7:0]  in_byte;
   logic [8:0]  in_addr;
   logic [15:0] in_value;
   logic        accept;
   assign in_byte  = req_tdata[7:0];
   assign in_addr  = req_tdata[16:8];
   assign in_value = req_tdata[32:17];

   // memories
   logic [7:0]  buf_mem  [msre_pkg::FRAME_CAPACITY];
   logic [15:0] hold_mem [msre_pkg::REGISTER_DEPTH];
   logic        coil_mem [msre_pkg::BIT_POINT_DEPTH];
   logic        in_mem   [msre_pkg::BIT_POINT_DEPTH];

   logic              buf_we, buf_re, buf_ok;
   logic [BUF_AW-1:0] buf_wa, buf_ra;
   logic [7:0]        buf_wd, buf_rd_ff;
   logic              buf_ok_ff;
   logic              hold_we, hold_re;
   logic [HR_AW-1:0]  hold_wa, hold_ra;
   logic [15:0]       hold_wd, hold_rd_ff;
   logic              coil_we, coil_re, coil_wd, coil_rd_ff;
   logic [BP_AW-1:0]  coil_wa, coil_ra;
   logic              in_we, in_re, in_wd, in_rd_ff;
   logic [BP_AW-1:0]  in_wa, in_ra;

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      if (buf_re) begin
         buf_rd_ff <= buf_mem[buf_ra];
         buf_ok_ff <= buf_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[hold_wa] <= hold_wd;
      end
      if (hold_re) begin
         hold_rd_ff <= hold_mem[hold_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (coil_we) begin
         coil_mem[coil_wa] <= coil_wd;
      end
      if (coil_re) begin
         coil_rd_ff <= coil_mem[coil_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_wa] <= in_wd;
      end
      if (in_re) begin
         in_rd_ff <= in_mem[in_ra];
      end
   end

   // sequencer state
   msre_pkg::state_type state_ff, state_in;
   logic [BP_AW-1:0] clr_ff, clr_in;
   logic [LEN_W-1:0] len_ff, len_in, flen_ff, flen_in;
   logic [7:0]  hdr_ff [HDR_N];
   logic [7:0]  hdr_in [HDR_N];
   logic [7:0]  fc_ff, fc_in, exc_ff, exc_in, dbyte_ff, dbyte_in;
   logic [15:0] start_ff, start_in, qty_ff, qty_in;
   logic [1:0]  kind_ff, kind_in;
   logic [9:0]  chg_ff, chg_in, idx_ff, idx_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic        rflag_ff, rflag_in;

   msre_pkg::push_type pk_push;
   logic               pk_ready;

   logic [7:0]  hm [HDR_N];
   logic [15:0] d_start, d_qty;
   logic [16:0] d_sum;
   logic [BP_AW-1:0] pt_addr;
   logic [8:0]  bidx;
   logic [9:0]  idx_next;
   logic [7:0]  bmask;

   assign req_tready = (state_ff == msre_pkg::S_IDLE) && pk_ready;
   assign accept     = req_tvalid && req_tready;
   assign pt_addr    = start_ff[BP_AW-1:0] + idx_ff[BP_AW-1:0];
   assign idx_next   = idx_ff + 10'd1;
   assign bmask      = buf_ok_ff ? buf_rd_ff : 8'd0;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      len_in   = len_ff;
      flen_in  = flen_ff;
      hdr_in   = hdr_ff;
      fc_in    = fc_ff;
      exc_in   = exc_ff;
      dbyte_in = dbyte_ff;
      start_in = start_ff;
      qty_in   = qty_ff;
      kind_in  = kind_ff;
      chg_in   = chg_ff;
      idx_in   = idx_ff;
      hidx_in  = hidx_ff;
      rflag_in = rflag_ff;
      buf_we = 1'b0; buf_wa = len_ff[BUF_AW-1:0]; buf_wd = in_byte;
      buf_re = 1'b0; buf_ra = '0; buf_ok = 1'b0;
      hold_we = 1'b0; hold_wa = in_addr[HR_AW-1:0]; hold_wd = in_value;
      hold_re = 1'b0; hold_ra = in_addr[HR_AW-1:0];
      coil_we = 1'b0; coil_wa = pt_addr; coil_wd = 1'b0;
      coil_re = 1'b0; coil_ra = in_addr[BP_AW-1:0];
      in_we = 1'b0; in_wa = in_addr[BP_AW-1:0]; in_wd = in_value[0];
      in_re = 1'b0; in_ra = pt_addr;
      pk_push = '0;
      bidx = '0;
      for (int i = 0; i < HDR_N; i++) begin
         hm[i] = (flen_ff > LEN_W'(i)) ? hdr_ff[i] : 8'd0;
      end
      d_start = {hm[2], hm[3]};
      d_qty   = {hm[4], hm[5]};
      d_sum   = {1'b0, d_start} + {1'b0, d_qty};

      unique case (state_ff)
         msre_pkg::S_CLEAR: begin
            hold_we = 1'b1; hold_wa = clr_ff[HR_AW-1:0]; hold_wd = '0;
            coil_we = 1'b1; coil_wa = clr_ff; coil_wd = 1'b0;
            in_we   = 1'b1; in_wa   = clr_ff; in_wd   = 1'b0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == BP_AW'(msre_pkg::BIT_POINT_DEPTH - 1)) begin
               state_in = msre_pkg::S_IDLE;
            end
         end
         msre_pkg::S_IDLE: begin
            if (accept) begin
               pk_push.last = 1'b1;
               unique case (req_tuser)
                  msre_pkg::OP_FRAME: begin
                     if (len_ff < LEN_W'(msre_pkg::FRAME_CAPACITY)) begin
                        buf_we = 1'b1;
                        len_in = len_ff + 1'b1;
                        if (len_ff < LEN_W'(HDR_N)) begin
                           hdr_in[len_ff[msre_pkg::HDR_AW-1:0]] = in_byte;
                        end
                     end
                     if (req_tlast) begin
                        flen_in  = len_in;
                        len_in   = '0;
                        state_in = msre_pkg::S_DECODE;
                     end
                  end
                  msre_pkg::OP_REG_WRITE: begin
                     pk_push.valid = 1'b1;
                     if (in_addr < {2'b0, eff_hr}) begin
                        hold_we        = 1'b1;
                        pk_push.status = msre_pkg::ST_DONE;
                     end else begin
                        pk_push.status = msre_pkg::ST_REJECTED;
                     end
                  end
                  msre_pkg::OP_INPUT_SET: begin
                     pk_push.valid = 1'b1;
                     if ({1'b0, in_addr} < eff_di) begin
                        in_we          = 1'b1;
                        pk_push.status = msre_pkg::ST_DONE;
                     end else begin
                        pk_push.status = msre_pkg::ST_REJECTED;
                     end
                  end
                  msre_pkg::OP_READ: begin
                     coil_re  = 1'b1;
                     hold_re  = 1'b1;
                     rflag_in = (in_addr[BP_AW-1:HR_AW] == '0);
                     state_in = msre_pkg::S_LREAD;
                  end
               endcase
            end
         end
         msre_pkg::S_LREAD: begin
            if (pk_ready) begin
               pk_push.valid     = 1'b1;
               pk_push.last      = 1'b1;
               pk_push.status    = msre_pkg::ST_READ;
               pk_push.coil      = coil_rd_ff;
               pk_push.reg_value = rflag_ff ? hold_rd_ff : 16'd0;
               state_in          = msre_pkg::S_IDLE;
            end
         end
         msre_pkg::S_DECODE: begin
            hdr_in   = hm;
            fc_in    = hm[1];
            start_in = d_start;
            qty_in   = d_qty;
            idx_in   = '0;
            hidx_in  = '0;
            dbyte_in = '0;
            chg_in   = d_qty[9:0];
            exc_in   = msre_pkg::EXC_ILLEGAL_ADDRESS;
            if (flen_ff < LEN_W'(msre_pkg::MIN_FRAME_BYTES) ||
                (hm[0] != unit_ff && hm[0] != 8'd0)) begin
               state_in = msre_pkg::S_DROP;
            end else begin
               unique case (hm[1])
                  msre_pkg::FC_READ_INPUTS: begin
                     state_in = (d_sum > {7'd0, eff_di}) ? msre_pkg::S_EXC : msre_pkg::S_RHDR;
                  end
                  msre_pkg::FC_READ_HOLDING: begin
                     state_in = (d_sum > {10'd0, eff_hr}) ? msre_pkg::S_EXC : msre_pkg::S_RHDR;
                  end
                  msre_pkg::FC_WRITE_COIL: begin
                     kind_in  = msre_pkg::KIND_COILS;
                     chg_in   = 10'd1;
                     state_in = (d_start >= {6'd0, eff_cl}) ? msre_pkg::S_EXC :
                                msre_pkg::S_SCOIL;
                  end
                  msre_pkg::FC_WRITE_COILS: begin
                     kind_in = msre_pkg::KIND_COILS;
                     if (d_sum > {7'd0, eff_cl}) begin
                        state_in = msre_pkg::S_EXC;
                     end else begin
                        state_in = (d_qty == '0) ? msre_pkg::S_ECHO : msre_pkg::S_WC_RD;
                     end
                  end
                  msre_pkg::FC_WRITE_REGS: begin
                     kind_in = msre_pkg::KIND_HOLDING;
                     if (d_sum > {10'd0, eff_hr}) begin
                        state_in = msre_pkg::S_EXC;
                     end else begin
                        state_in = (d_qty == '0) ? msre_pkg::S_ECHO : msre_pkg::S_WR_RDH;
                     end
                  end
                  default: begin
                     exc_in   = msre_pkg::EXC_ILLEGAL_FUNCTION;
                     state_in = msre_pkg::S_EXC;
                  end
               endcase
            end
         end
         msre_pkg::S_DROP: begin
            if (pk_ready) begin
               pk_push.valid  = 1'b1;
               pk_push.last   = 1'b1;
               pk_push.status = msre_pkg::ST_DROPPED;
               state_in       = msre_pkg::S_IDLE;
            end
         end
         msre_pkg::S_EXC: begin
            if (pk_ready) begin
               pk_push.valid    = 1'b1;
               pk_push.has_byte = 1'b1;
               pk_push.last     = (hidx_ff == 3'd2);
               unique case (hidx_ff)
                  3'd0:    pk_push.data = hdr_ff[0];
                  3'd1:    pk_push.data = hdr_ff[1] | msre_pkg::FC_EXC_FLAG;
                  default: pk_push.data = exc_ff;
               endcase
               hidx_in = hidx_ff + 3'd1;
               if (hidx_ff == 3'd2) begin
                  state_in = msre_pkg::S_IDLE;
               end
            end
         end
         msre_pkg::S_RHDR: begin
            if (pk_ready) begin
               pk_push.valid    = 1'b1;
               pk_push.has_byte = 1'b1;
               pk_push.last     = (hidx_ff == 3'd2) && (qty_ff == '0);
               unique case (hidx_ff)
                  3'd0:    pk_push.data = unit_ff;
                  3'd1:    pk_push.data = fc_ff;
                  default: begin
                     // byte count: bytes of packed bits, or two per register
                     if (fc_ff == msre_pkg::FC_READ_INPUTS) begin
                        pk_push.data = 8'((qty_ff + 16'd7) >> 3);
                     end else begin
                        pk_push.data = {qty_ff[6:0], 1'b0};
                     end
                  end
               endcase
               hidx_in = hidx_ff + 3'd1;
               if (hidx_ff == 3'd2) begin
                  if (qty_ff == '0) begin
                     state_in = msre_pkg::S_IDLE;
                  end else if (fc_ff == msre_pkg::FC_READ_INPUTS) begin
                     state_in = msre_pkg::S_DI_RD;
                  end else begin
                     state_in = msre_pkg::S_HR_RD;
                  end
               end
            end
         end
         msre_pkg::S_DI_RD: begin
            in_re    = 1'b1;
            state_in = msre_pkg::S_DI_ACC;
         end
         msre_pkg::S_DI_ACC: begin
            dbyte_in[idx_ff[2:0]] = in_rd_ff;
            idx_in = idx_next;
            if (idx_ff[2:0] == 3'd7 || {6'd0, idx_next} == qty_ff) begin
               state_in = msre_pkg::S_DI_PUSH;
            end else begin
               state_in = msre_pkg::S_DI_RD;
            end
         end
         msre_pkg::S_DI_PUSH: begin
            if (pk_ready) begin
               pk_push.valid    = 1'b1;
               pk_push.has_byte = 1'b1;
               pk_push.data     = dbyte_ff;
               pk_push.last     = ({6'd0, idx_ff} == qty_ff);
               dbyte_in         = '0;
               state_in         = pk_push.last ? msre_pkg::S_IDLE : msre_pkg::S_DI_RD;
            end
         end
         msre_pkg::S_HR_RD: begin
            hold_re  = 1'b1;
            hold_ra  = pt_addr[HR_AW-1:0];
            state_in = msre_pkg::S_HR_HI;
         end
         msre_pkg::S_HR_HI: begin
            if (pk_ready) begin
               pk_push.valid    = 1'b1;
               pk_push.has_byte = 1'b1;
               pk_push.data     = hold_rd_ff[15:8];
               state_in         = msre_pkg::S_HR_LO;
            end
         end
         msre_pkg::S_HR_LO: begin
            if (pk_ready) begin
               pk_push.valid    = 1'b1;
               pk_push.has_byte = 1'b1;
               pk_push.data     = hold_rd_ff[7:0];
               pk_push.last     = ({6'd0, idx_next} == qty_ff);
               idx_in           = idx_next;
               state_in         = pk_push.last ? msre_pkg::S_IDLE : msre_pkg::S_HR_RD;
            end
         end
         msre_pkg::S_SCOIL: begin
            coil_we  = 1'b1;
            coil_wa  = start_ff[BP_AW-1:0];
            coil_wd  = (qty_ff == msre_pkg::COIL_ON);
            state_in = msre_pkg::S_ECHO;
         end
         msre_pkg::S_WC_RD: begin
            // data byte i/8 of the coil values starts at request byte 7
            bidx     = 9'd7 + {2'd0, idx_ff[9:3]};
            buf_re   = 1'b1;
            buf_ra   = bidx[BUF_AW-1:0];
            buf_ok   = (LEN_W'(bidx) < flen_ff) && (bidx[8] == 1'b0);
            state_in = msre_pkg::S_WC_BYTE;
         end
         msre_pkg::S_WC_BYTE: begin
            dbyte_in = bmask;
            state_in = msre_pkg::S_WC_WR;
         end
         msre_pkg::S_WC_WR: begin
            coil_we = 1'b1;
            coil_wd = dbyte_ff[idx_ff[2:0]];
            idx_in  = idx_next;
            if ({6'd0, idx_next} == qty_ff) begin
               state_in = msre_pkg::S_ECHO;
            end else if (idx_ff[2:0] == 3'd7) begin
               state_in = msre_pkg::S_WC_RD;
            end
         end
         msre_pkg::S_WR_RDH: begin
            bidx     = 9'd7 + {idx_ff[7:0], 1'b0};
            buf_re   = 1'b1;
            buf_ra   = bidx[BUF_AW-1:0];
            buf_ok   = (LEN_W'(bidx) < flen_ff) && (bidx[8] == 1'b0);
            state_in = msre_pkg::S_WR_RDL;
         end
         msre_pkg::S_WR_RDL: begin
            bidx     = 9'd8 + {idx_ff[7:0], 1'b0};
            dbyte_in = bmask;
            buf_re   = 1'b1;
            buf_ra   = bidx[BUF_AW-1:0];
            buf_ok   = (LEN_W'(bidx) < flen_ff) && (bidx[8] == 1'b0);
            state_in = msre_pkg::S_WR_WR;
         end
         msre_pkg::S_WR_WR: begin
            hold_we  = 1'b1;
            hold_wa  = pt_addr[HR_AW-1:0];
            hold_wd  = {dbyte_ff, bmask};
            idx_in   = idx_next;
            state_in = ({6'd0, idx_next} == qty_ff) ? msre_pkg::S_ECHO : msre_pkg::S_WR_RDH;
         end
         msre_pkg::S_ECHO: begin
            if (pk_ready) begin
               pk_push.valid    = 1'b1;
               pk_push.has_byte = 1'b1;
               pk_push.data     = hdr_ff[hidx_ff];
               pk_push.last     = (hidx_ff == 3'(HDR_N - 1));
               pk_push.kind     = kind_ff;
               pk_push.start    = start_ff[8:0];
               pk_push.count    = chg_ff;
               hidx_in          = hidx_ff + 3'd1;
               if (pk_push.last) begin
                  state_in = msre_pkg::S_IDLE;
               end
            end
         end
         default: state_in = msre_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msre_pkg::S_CLEAR;
         clr_ff   <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         len_ff   <= len_in;
      end
      flen_ff  <= flen_in;
      hdr_ff   <= hdr_in;
      fc_ff    <= fc_in;
      exc_ff   <= exc_in;
      dbyte_ff <= dbyte_in;
      start_ff <= start_in;
      qty_ff   <= qty_in;
      kind_ff  <= kind_in;
      chg_ff   <= chg_in;
      idx_ff   <= idx_in;
      hidx_ff  <= hidx_in;
      rflag_ff <= rflag_in;
   end

   msre_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .push       (pk_push),
      .push_ready (pk_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   a_push_into_free: assert property (@(posedge clock) disable iff (reset)
      pk_push.valid |-> pk_ready)
      else $error("byte pushed into a busy packer");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(msre_pkg::FRAME_CAPACITY))
      else $error("frame length past capacity");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("word taken during clearing pass");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msre_pkg::S_HR_RD || state_ff == msre_pkg::S_DI_RD) |->
      ({6'd0, idx_ff} < qty_ff))
      else $error("point walk past quantity");
`endif

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for modbus_slave_request_engine
// runs directed and random request frames and local ops against a built-in predictor
// depends on msre_pkg and the engine rtl
`timescale 1ns / 1ps

module tb_top;
   import msre_pkg::*;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [8:0]  start;
      logic [9:0]  count;
      logic        coil;
      logic [15:0] rd_reg;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic [1:0] req_tuser = OP_FRAME;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   modbus_slave_request_engine i_dut (.*);

   // predictor state
   logic [7:0]  cfg_unit = 8'd1;
   logic [9:0]  cfg_di = 10'd512;
   logic [6:0]  cfg_hr = 7'd64;
   logic [9:0]  cfg_cl = 10'd512;
   logic [7:0]  frame_buf [0:FRAME_CAPACITY-1];
   int          frame_len = 0;
   logic [15:0] hold_regs [0:REGISTER_DEPTH-1];
   logic        coils [0:BIT_POINT_DEPTH-1];
   logic        inputs [0:BIT_POINT_DEPTH-1];
   logic [7:0]  resp [0:255];

   result_type  expected_q [$];
   logic [7:0]  frame_q [$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_off = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[63:0], rsp_tdata[67:64], rsp_tlast, rsp_tuser[2:0], rsp_tuser[4:3],
                 rsp_tdata[76:68], rsp_tdata[86:77], rsp_tdata[87], rsp_tdata[103:88]};
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_q.pop_front();
            if (got.word !== want.word || got.nbytes !== want.nbytes ||
                got.last !== want.last || got.status !== want.status ||
                got.kind !== want.kind || got.start !== want.start ||
                got.count !== want.count || got.coil !== want.coil ||
                got.rd_reg !== want.rd_reg) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   // ---------------- predictor ----------------
   function automatic int frame_at(int i);
      return (i < frame_len) ? frame_buf[i] : 0;
   endfunction

   function automatic void push_results(int n, logic [2:0] st, logic [1:0] kind,
                                        int start, int count, logic coil, logic [15:0] rv);
      int items;
      result_type r;
      items = (n != 0) ? (n + 7) / 8 : 1;
      for (int k = 0; k < items; k++) begin
         r = '0;
         for (int j = 0; j < 8; j++) begin
            r.word = r.word << 8;
            if (k * 8 + j < n) begin
               r.word[7:0] = resp[k * 8 + j];
               r.nbytes++;
            end
         end
         r.last = (k + 1 == items);
         r.status = st;
         r.kind = kind;
         r.start = start[8:0];
         r.count = count[9:0];
         r.coil = coil;
         r.rd_reg = rv;
         expected_q.push_back(r);
      end
   endfunction

   function automatic void push_exception(logic [7:0] code);
      resp[0] = 8'(frame_at(0));
      resp[1] = 8'(frame_at(1)) | FC_EXC_FLAG;
      resp[2] = code;
      push_results(3, ST_RESPONSE, KIND_NONE, 0, 0, 1'b0, '0);
   endfunction

   function automatic void push_echo(logic [1:0] kind, int start, int count);
      for (int i = 0; i < HDR_BYTES; i++) resp[i] = 8'(frame_at(i));
      push_results(HDR_BYTES, ST_RESPONSE, kind, start, count, 1'b0, '0);
   endfunction

   function automatic void serve_request();
      int fc, start, qty, lim, n;
      if (frame_len < MIN_FRAME_BYTES ||
          (frame_at(0) != cfg_unit && frame_at(0) != 0)) begin
         push_results(0, ST_DROPPED, KIND_NONE, 0, 0, 1'b0, '0);
         return;
      end
      fc = frame_at(1);
      start = (frame_at(2) << 8) | frame_at(3);
      qty = (frame_at(4) << 8) | frame_at(5);
      for (int i = 0; i < 256; i++) resp[i] = 8'h00;
      case (fc[7:0])
         FC_READ_INPUTS: begin
            lim = (cfg_di > BIT_POINT_DEPTH) ? BIT_POINT_DEPTH : cfg_di;
            if (start + qty > lim) push_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               n = (qty + 7) / 8;
               resp[0] = cfg_unit;
               resp[1] = 8'(fc);
               resp[2] = 8'(n);
               for (int i = 0; i < qty; i++)
                  if (inputs[start + i]) resp[3 + i / 8][i % 8] = 1'b1;
               push_results(3 + n, ST_RESPONSE, KIND_NONE, 0, 0, 1'b0, '0);
            end
         end
         FC_READ_HOLDING: begin
            lim = (cfg_hr > REGISTER_DEPTH) ? REGISTER_DEPTH : cfg_hr;
            if (start + qty > lim) push_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               resp[0] = cfg_unit;
               resp[1] = 8'(fc);
               resp[2] = 8'(qty * 2);
               for (int i = 0; i < qty; i++) begin
                  resp[3 + 2 * i] = hold_regs[start + i][15:8];
                  resp[4 + 2 * i] = hold_regs[start + i][7:0];
               end
               push_results(3 + 2 * qty, ST_RESPONSE, KIND_NONE, 0, 0, 1'b0, '0);
            end
         end
         FC_WRITE_COIL: begin
            lim = (cfg_cl > BIT_POINT_DEPTH) ? BIT_POINT_DEPTH : cfg_cl;
            if (start >= lim) push_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               coils[start] = (qty == COIL_ON);
               push_echo(KIND_COILS, start, 1);
            end
         end
         FC_WRITE_COILS: begin
            lim = (cfg_cl > BIT_POINT_DEPTH) ? BIT_POINT_DEPTH : cfg_cl;
            if (start + qty > lim) push_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               for (int i = 0; i < qty; i++)
                  coils[start + i] = 1'((frame_at(7 + i / 8) >> (i % 8)) & 1);
               push_echo(KIND_COILS, start, qty);
            end
         end
         FC_WRITE_REGS: begin
            lim = (cfg_hr > REGISTER_DEPTH) ? REGISTER_DEPTH : cfg_hr;
            if (start + qty > lim) push_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               for (int i = 0; i < qty; i++)
                  hold_regs[start + i] =
                     16'((frame_at(7 + 2 * i) << 8) | frame_at(8 + 2 * i));
               push_echo(KIND_HOLDING, start, qty);
            end
         end
         default: push_exception(EXC_ILLEGAL_FUNCTION);
      endcase
   endfunction

   function automatic void predict_word(logic [1:0] op, logic [7:0] b, logic fin,
                                        logic [8:0] addr, logic [15:0] val);
      case (op)
         OP_FRAME: begin
            if (frame_len < FRAME_CAPACITY) begin
               frame_buf[frame_len] = b;
               frame_len++;
            end
            if (fin) begin
               serve_request();
               frame_len = 0;
            end
         end
         OP_REG_WRITE: begin
            if (addr < ((cfg_hr > REGISTER_DEPTH) ? REGISTER_DEPTH : cfg_hr)) begin
               hold_regs[addr] = val;
               push_results(0, ST_DONE, KIND_NONE, 0, 0, 1'b0, '0);
            end else push_results(0, ST_REJECTED, KIND_NONE, 0, 0, 1'b0, '0);
         end
         OP_INPUT_SET: begin
            if (addr < ((cfg_di > BIT_POINT_DEPTH) ? BIT_POINT_DEPTH : cfg_di)) begin
               inputs[addr] = val[0];
               push_results(0, ST_DONE, KIND_NONE, 0, 0, 1'b0, '0);
            end else push_results(0, ST_REJECTED, KIND_NONE, 0, 0, 1'b0, '0);
         end
         default: begin
            push_results(0, ST_READ, KIND_NONE, 0, 0, coils[addr],
                         (addr < REGISTER_DEPTH) ? hold_regs[addr[5:0]] : 16'h0000);
         end
      endcase
   endfunction

   // ---------------- drivers ----------------
   // called at a rising edge; returns at the edge where the word was taken
   task automatic send_word(logic [1:0] op, logic [7:0] b, logic fin,
                            logic [8:0] addr, logic [15:0] val);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tlast <= fin;
      req_tdata <= {7'b0, val, addr, b};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predict_word(op, b, fin, addr, val);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_word(OP_FRAME, frame_q[i], i == frame_q.size() - 1,
                   9'($urandom_range(511)), 16'($urandom_range(65535)));
   endtask

   task automatic send_local(logic [1:0] op, logic [8:0] addr, logic [15:0] val);
      send_word(op, 8'($urandom_range(255)), 1'($urandom_range(1)), addr, val);
   endtask

   task automatic build_head(logic [7:0] unit, logic [7:0] fc, int start, int qty);
      frame_q = '{unit, fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_UNIT_ID:  cfg_unit = val[7:0];
         REG_DI_COUNT: cfg_di = val[9:0];
         REG_HR_COUNT: cfg_hr = val[6:0];
         default:      cfg_cl = val[9:0];
      endcase
      @(posedge clock);
   endtask

   // ---------------- tests ----------------
   task automatic test_local_ops();
      send_local(OP_REG_WRITE, 9'd0, 16'hFFFF);
      send_local(OP_REG_WRITE, 9'd63, 16'hA55A);
      send_local(OP_REG_WRITE, 9'd64, 16'h1234);  // past the store: rejected
      send_local(OP_INPUT_SET, 9'd0, 16'h0001);
      send_local(OP_INPUT_SET, 9'd511, 16'hFFFF);
      send_local(OP_INPUT_SET, 9'd3, 16'hFFFE);
      send_local(OP_READ, 9'd63, 16'h0000);
      send_local(OP_READ, 9'd511, 16'hFFFF);
   endtask

   task automatic test_requests();
      build_head(8'd1, FC_READ_INPUTS, 0, 9);
      send_frame();
      build_head(8'd1, FC_READ_INPUTS, 505, 7);
      send_frame();
      build_head(8'd0, FC_READ_HOLDING, 62, 2);   // broadcast
      send_frame();
      build_head(8'd1, FC_WRITE_COIL, 511, COIL_ON);
      send_frame();
      build_head(8'd1, FC_WRITE_COIL, 10, 16'h1234);
      send_frame();
      build_head(8'd1, FC_WRITE_COILS, 500, 12);
      frame_q.push_back(8'd2); frame_q.push_back(8'hA5); frame_q.push_back(8'h0F);
      send_frame();
      build_head(8'd1, FC_WRITE_REGS, 1, 3);
      frame_q.push_back(8'd6);
      frame_q.push_back(8'h12); frame_q.push_back(8'h34); frame_q.push_back(8'h56);
      send_frame();                              // last data bytes missing
      build_head(8'd1, FC_READ_HOLDING, 0, 4);
      send_frame();
      build_head(8'd1, FC_WRITE_REGS, 511, 0);   // zero quantity
      send_frame();
      build_head(8'd1, FC_READ_INPUTS, 0, 0);
      send_frame();
      send_local(OP_READ, 9'd505, 16'h0000);
   endtask

   task automatic test_exceptions_and_drops();
      build_head(8'd1, 8'd7, 0, 1);
      send_frame();
      build_head(8'd1, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_frame();
      build_head(8'd1, FC_READ_HOLDING, 60, 5);
      send_frame();
      build_head(8'd1, FC_WRITE_COIL, 512, COIL_ON);
      send_frame();
      frame_q = '{8'd1, FC_READ_HOLDING, 8'd0};  // too short
      send_frame();
      build_head(8'd2, FC_READ_HOLDING, 0, 1);   // other unit
      send_frame();
      frame_q = '{8'd1, FC_READ_HOLDING, 8'd0, 8'd1};   // minimum length, qty from zeros
      send_frame();
      // local op in the middle of a frame
      send_word(OP_FRAME, 8'd1, 1'b0, 9'd0, 16'd0);
      send_word(OP_FRAME, FC_READ_HOLDING, 1'b0, 9'd0, 16'd0);
      send_local(OP_REG_WRITE, 9'd5, 16'hBEEF);
      send_word(OP_FRAME, 8'd0, 1'b0, 9'd0, 16'd0);
      send_word(OP_FRAME, 8'd4, 1'b0, 9'd0, 16'd0);
      send_word(OP_FRAME, 8'd0, 1'b0, 9'd0, 16'd0);
      send_word(OP_FRAME, 8'd3, 1'b1, 9'd0, 16'd0);
   endtask

   task automatic test_buffer_full();
      build_head(8'd1, FC_WRITE_REGS, 0, 64);
      frame_q.push_back(8'd128);
      for (int i = 0; i < 252; i++) frame_q.push_back(8'($urandom_range(255)));
      send_frame();
      build_head(8'd1, FC_READ_HOLDING, 0, 64);
      send_frame();
   endtask

   task automatic random_frame();
      int kind, qty, start, lim, nb;
      logic [7:0] unit, fc;
      kind = $urandom_range(99);
      unit = (kind < 80) ? cfg_unit : (kind < 90) ? 8'd0 : 8'($urandom_range(255));
      case ($urandom_range(5))
         0: fc = FC_READ_INPUTS;
         1: fc = FC_READ_HOLDING;
         2: fc = FC_WRITE_COIL;
         3: fc = FC_WRITE_COILS;
         4: fc = FC_WRITE_REGS;
         default: fc = 8'($urandom_range(255));
      endcase
      lim = (fc == FC_READ_HOLDING || fc == FC_WRITE_REGS) ? 64 : 512;
      qty = ($urandom_range(9) == 0) ? $urandom_range(lim) : $urandom_range(12);
      start = $urandom_range(lim);
      if ($urandom_range(9) == 0) start = $urandom_range(65535);
      else if (start + qty > lim && $urandom_range(3) != 0) start = lim - qty;
      if (fc == FC_WRITE_COIL) qty = ($urandom_range(1) != 0) ? COIL_ON : $urandom_range(65535);
      build_head(unit, fc, start, qty);
      nb = (fc == FC_WRITE_COILS) ? (qty + 7) / 8 : (fc == FC_WRITE_REGS) ? 2 * qty : 0;
      if (nb > 0) begin
         frame_q.push_back(8'(nb));
         for (int i = 0; i < nb; i++) frame_q.push_back(8'($urandom_range(255)));
      end
      // occasionally cut the frame short
      if ($urandom_range(9) == 0)
         while (frame_q.size() > 1 && $urandom_range(3) != 0) void'(frame_q.pop_back());
      send_frame();
   endtask

   task automatic test_random_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 65) random_frame();
         else send_local(2'($urandom_range(1, 3)), 9'($urandom_range(511)),
                         16'($urandom_range(65535)));
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 400;
      for (int n = 0; n < 12; n++) send_local(OP_READ, 9'($urandom_range(511)), 16'h0000);
   endtask

   task automatic random_config();
      csr_write(REG_UNIT_ID, $urandom_range(255));
      csr_write(REG_DI_COUNT, $urandom_range(1023));
      csr_write(REG_HR_COUNT, $urandom_range(127));
      csr_write(REG_CL_COUNT, $urandom_range(1023));
   endtask

   initial begin
      for (int i = 0; i < REGISTER_DEPTH; i++) hold_regs[i] = '0;
      for (int i = 0; i < BIT_POINT_DEPTH; i++) begin
         coils[i] = 1'b0;
         inputs[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_local_ops();
      test_requests();
      test_exceptions_and_drops();
      test_buffer_full();
      wait_idle();

      // extreme settings: zero counts, then counts above the stores
      csr_write(REG_UNIT_ID, 32'd255);
      csr_write(REG_DI_COUNT, 32'd0);
      csr_write(REG_HR_COUNT, 32'd0);
      csr_write(REG_CL_COUNT, 32'd0);
      test_random_phase(0, 0, 3);
      wait_idle();
      csr_write(REG_UNIT_ID, 32'd0);
      csr_write(REG_DI_COUNT, 32'd1023);
      csr_write(REG_HR_COUNT, 32'd127);
      csr_write(REG_CL_COUNT, 32'd1023);
      test_random_phase(0, 0, 4);
      wait_idle();

      random_config();
      test_random_phase(69, 0, 4);
      wait_idle();
      csr_write(REG_UNIT_ID, 32'd1);
      csr_write(REG_DI_COUNT, 32'd512);
      csr_write(REG_HR_COUNT, 32'd64);
      csr_write(REG_CL_COUNT, 32'd512);
      test_random_phase(0, 69, 4);
      wait_idle();
      random_config();
      test_random_phase(31, 31, 4);
      test_backpressure();
      test_random_phase(0, 0, 2);

      wait_idle();
      if (errors == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
